[hw/rtl/tss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and codes for the timed serve sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  // call kinds carried on the input tuser
  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_REQUEST = 2'd1,
    FN_CANCEL  = 2'd2,
    FN_INIT    = 2'd3
  } func_t;

  // system state codes
  localparam logic [2:0] SYS_START      = 3'd0;
  localparam logic [2:0] SYS_START_BUSY = 3'd1;
  localparam logic [2:0] SYS_JAM        = 3'd4;
  localparam logic [2:0] SYS_COMMS      = 3'd5;

  // serve arm command codes
  localparam logic [1:0] SERVE_NONE   = 2'd0;
  localparam logic [1:0] SERVE_READY  = 2'd1;
  localparam logic [1:0] SERVE_ACTION = 2'd2;
  localparam logic [1:0] SERVE_RETURN = 2'd3;

  // cushion command codes
  localparam logic [1:0] CUSH_NONE   = 2'd0;
  localparam logic [1:0] CUSH_ACTION = 2'd1;
  localparam logic [1:0] CUSH_READY  = 2'd2;

  // chassis command codes
  localparam logic [1:0] CHAS_NONE = 2'd0;
  localparam logic [1:0] CHAS_FEED = 2'd1;
  localparam logic [1:0] CHAS_STOP = 2'd2;

  // action step codes
  localparam logic [1:0] STEP_IDLE   = 2'd0;
  localparam logic [1:0] STEP_WINDUP = 2'd1;
  localparam logic [1:0] STEP_FEED   = 2'd2;
  localparam logic [1:0] STEP_RETURN = 2'd3;

  // init phase codes
  localparam logic [1:0] PHASE_WAIT  = 2'd0;
  localparam logic [1:0] PHASE_RETRY = 2'd1;
  localparam logic [1:0] PHASE_READY = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INIT_DELAY       = 3'd0;
  localparam logic [2:0] REG_INIT_RETRY_DELAY = 3'd1;
  localparam logic [2:0] REG_WINDUP_TIME      = 3'd2;
  localparam logic [2:0] REG_FIRE_TIME        = 3'd3;
  localparam logic [2:0] REG_FEED_STOP_TIME   = 3'd4;
  localparam logic [2:0] REG_RETURN_TIME      = 3'd5;
  localparam logic [2:0] REG_MAX_RETRIES      = 3'd6;
  localparam logic [2:0] REG_CUSHION_GAIN     = 3'd7;

  // register reset values
  localparam logic [15:0] RST_INIT_DELAY       = 16'd500;
  localparam logic [15:0] RST_INIT_RETRY_DELAY = 16'd200;
  localparam logic [15:0] RST_WINDUP_TIME      = 16'd100;
  localparam logic [15:0] RST_FIRE_TIME        = 16'd600;
  localparam logic [15:0] RST_FEED_STOP_TIME   = 16'd750;
  localparam logic [15:0] RST_RETURN_TIME      = 16'd1350;
  localparam logic [1:0]  RST_MAX_RETRIES      = 2'd3;

  typedef struct packed {
    logic [15:0] init_delay;
    logic [15:0] init_retry_delay;
    logic [15:0] windup_time;
    logic [15:0] fire_time;
    logic [15:0] feed_stop_time;
    logic [15:0] return_time;
    logic [1:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    logic [1:0] init_phase;
    logic       request_flag;
    logic [1:0] action_step;
    logic [1:0] fail_count;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] serve_cmd;
    logic [1:0] cushion_cmd;
    logic [1:0] chassis_cmd;
    logic       hard_stop;
    logic       state_write;
    logic [2:0] state_value;
    logic       ready_res;
    logic       idle;
  } res_t;

  // bump the failure count; msb flags that the retry limit is reached
  function automatic logic [2:0] fail_step(input logic [1:0] count,
                                           input logic [1:0] limit);
    logic [1:0] n;
    n = count + 2'd1;
    return {(n >= limit), n};
  endfunction

endpackage

[hw/rtl/tss_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_cfg_regs
// Timing and retry registers behind the plain write port.
// ----------------------------------------------------------------------------
module tss_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_wdata,
  output tss_pkg::cfg_t    cfg
);
  import tss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_delay       <= RST_INIT_DELAY;
      cfg.init_retry_delay <= RST_INIT_RETRY_DELAY;
      cfg.windup_time      <= RST_WINDUP_TIME;
      cfg.fire_time        <= RST_FIRE_TIME;
      cfg.feed_stop_time   <= RST_FEED_STOP_TIME;
      cfg.return_time      <= RST_RETURN_TIME;
      cfg.max_retries      <= RST_MAX_RETRIES;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_DELAY:       cfg.init_delay       <= cfg_wdata;
        REG_INIT_RETRY_DELAY: cfg.init_retry_delay <= cfg_wdata;
        REG_WINDUP_TIME:      cfg.windup_time      <= cfg_wdata;
        REG_FIRE_TIME:        cfg.fire_time        <= cfg_wdata;
        REG_FEED_STOP_TIME:   cfg.feed_stop_time   <= cfg_wdata;
        REG_RETURN_TIME:      cfg.return_time      <= cfg_wdata;
        REG_MAX_RETRIES:      cfg.max_retries      <= cfg_wdata[1:0];
        // cushion gain rides with the motor command outside this block
        REG_CUSHION_GAIN:     ;
        default:              ;
      endcase
    end
  end

endmodule

[hw/rtl/tss_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_step
// One-call update of the sequencer state and its command outputs.
// ----------------------------------------------------------------------------
module tss_step #(
  parameter int TICK_BITS = 32
) (
  input  tss_pkg::func_t       func,
  input  logic [TICK_BITS-1:0] now,
  input  logic [2:0]           sys,
  input  logic                 ok,
  input  tss_pkg::cfg_t        cfg,
  input  tss_pkg::ctrl_t       ctrl,
  input  logic [TICK_BITS-1:0] init_stamp,
  input  logic [TICK_BITS-1:0] action_stamp,
  output tss_pkg::ctrl_t       ctrl_next,
  output logic [TICK_BITS-1:0] init_stamp_next,
  output logic [TICK_BITS-1:0] action_stamp_next,
  output tss_pkg::res_t        res
);
  import tss_pkg::*;

  logic [1:0]           ip, st, fc;
  logic                 rf, trip;
  logic [TICK_BITS-1:0] is_v, as_v, init_el, act_el;
  logic [1:0]           o_serve, o_cush, o_chas;
  logic                 o_stop, o_wr;
  logic [2:0]           o_val;

  always_comb begin
    ip = ctrl.init_phase;
    rf = ctrl.request_flag;
    st = ctrl.action_step;
    fc = ctrl.fail_count;
    is_v = init_stamp;
    as_v = action_stamp;
    trip = 1'b0;
    o_serve = SERVE_NONE;
    o_cush = CUSH_NONE;
    o_chas = CHAS_NONE;
    o_stop = 1'b0;
    o_wr = 1'b0;
    o_val = SYS_START;
    init_el = now - init_stamp;
    act_el = '0;

    case (func)
      FN_TICK: begin
        if (sys inside {SYS_JAM, SYS_COMMS}) begin
          rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
          o_stop = 1'b1;
        end else begin
          // init phase: two ready commands with timed gaps
          if (ip == PHASE_WAIT) begin
            if (init_el >= TICK_BITS'(cfg.init_delay)) begin
              o_serve = SERVE_READY;
              if (ok) begin
                is_v = now; ip = PHASE_RETRY; fc = '0;
              end else begin
                {trip, fc} = fail_step(fc, cfg.max_retries);
              end
            end
          end else if (ip == PHASE_RETRY) begin
            if (init_el >= TICK_BITS'(cfg.init_retry_delay)) begin
              o_serve = SERVE_READY;
              if (ok) begin
                ip = PHASE_READY; fc = '0;
              end else begin
                {trip, fc} = fail_step(fc, cfg.max_retries);
              end
            end
          end
          if (trip) begin
            rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
            o_stop = 1'b1; o_wr = 1'b1; o_val = SYS_COMMS;
          end
          trip = 1'b0;

          // stale request dropped
          if (st == STEP_IDLE && rf && sys != SYS_START) rf = 1'b0;

          // start of the serve sequence
          if (st == STEP_IDLE && rf && ip[1]) begin
            o_cush = CUSH_ACTION;
            if (ok) begin
              rf = 1'b0; st = STEP_WINDUP; as_v = now; fc = '0;
              o_wr = 1'b1; o_val = SYS_START_BUSY;
            end else begin
              {trip, fc} = fail_step(fc, cfg.max_retries);
            end
          end
          if (trip) begin
            rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
            o_stop = 1'b1; o_wr = 1'b1; o_val = SYS_COMMS;
          end
          trip = 1'b0;

          act_el = now - as_v;
          case (st)
            STEP_WINDUP: begin
              if (act_el > TICK_BITS'(cfg.windup_time)) begin
                st = STEP_FEED; fc = '0;
              end
            end
            STEP_FEED: begin
              o_chas = CHAS_FEED;
              if (act_el > TICK_BITS'(cfg.fire_time)) begin
                o_serve = SERVE_ACTION;
                if (ok) begin
                  st = STEP_RETURN; fc = '0;
                end else begin
                  {trip, fc} = fail_step(fc, cfg.max_retries);
                end
              end
            end
            STEP_RETURN: begin
              if (act_el > TICK_BITS'(cfg.feed_stop_time)) o_chas = CHAS_STOP;
              o_cush = CUSH_READY;
              if (act_el > TICK_BITS'(cfg.return_time)) begin
                o_serve = SERVE_RETURN;
                if (ok) begin
                  st = STEP_IDLE; fc = '0;
                  if (sys == SYS_START_BUSY) begin
                    o_wr = 1'b1; o_val = SYS_START;
                  end
                end else begin
                  {trip, fc} = fail_step(fc, cfg.max_retries);
                end
              end
            end
            default: ;
          endcase
          if (trip) begin
            rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
            o_stop = 1'b1; o_wr = 1'b1; o_val = SYS_COMMS;
          end
        end
      end
      FN_REQUEST: begin
        if (sys == SYS_START && st == STEP_IDLE && ip[1]) rf = 1'b1;
      end
      FN_CANCEL: begin
        rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
        o_stop = 1'b1;
      end
      FN_INIT: begin
        ip = PHASE_WAIT;
        rf = 1'b0; st = STEP_IDLE; fc = '0; as_v = '0;
        is_v = now;
      end
      default: ;
    endcase

    ctrl_next.init_phase   = ip;
    ctrl_next.request_flag = rf;
    ctrl_next.action_step  = st;
    ctrl_next.fail_count   = fc;
    init_stamp_next        = is_v;
    action_stamp_next      = as_v;

    res.serve_cmd   = o_serve;
    res.cushion_cmd = o_cush;
    res.chassis_cmd = o_chas;
    res.hard_stop   = o_stop;
    res.state_write = o_wr;
    res.state_value = o_val;
    // phase three never occurs and counts as ready
    res.ready_res   = ip[1];
    res.idle        = (st == STEP_IDLE);
  end

endmodule

[hw/rtl/timed_serve_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_serve_sequencer
// Serve controller sequencer: init, request, cancel and tick calls in,
// serve / cushion / chassis command codes out.
// ----------------------------------------------------------------------------
// Each input transaction is one call on the serve controller and yields
// exactly one result transaction, in order. A call sits in an input register
// while the step logic updates the controller state and loads the result
// register, so a new call is taken every cycle and its result is presented on
// the master side from the result register, which follows the input register;
// only the result register stalling on m_tready holds the input back. The
// user must write the timing registers through cfg_we / cfg_index / cfg_wdata
// only while no call is in flight; the block itself does not enforce this.
// Time stamps are TICK_BITS wide and all elapsed times wrap at 2^TICK_BITS.
// ----------------------------------------------------------------------------
module timed_serve_sequencer #(
  parameter int TICK_BITS = 32   // 16 to 64
) (
  input  logic        clk,
  input  logic        rst,
  // call in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // now_time[31:0], system_state[34:32],
                                 // link_ok[35], zero [39:36]
  input  logic [1:0]  s_tuser,   // func[1:0]
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // serve_cmd[1:0], cushion_cmd[3:2],
                                 // chassis_cmd[5:4], hard_stop[6],
                                 // state_write[7], state_value[10:8],
                                 // ready_res[11], idle[12], zero [15:13]
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import tss_pkg::*;

  cfg_t                 cfg;
  ctrl_t                ctrl, ctrl_next;
  logic [TICK_BITS-1:0] init_stamp, init_stamp_next;
  logic [TICK_BITS-1:0] action_stamp, action_stamp_next;
  res_t                 res_next, res;

  // input register
  logic                 in_valid;
  func_t                in_func;
  logic [TICK_BITS-1:0] in_now;
  logic [2:0]           in_sys;
  logic                 in_ok;
  logic                 advance;

  // the held call moves on whenever the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  tss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // call payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= func_t'(s_tuser);
      in_now  <= TICK_BITS'(s_tdata[31:0]);
      in_sys  <= s_tdata[34:32];
      in_ok   <= s_tdata[35];
    end
  end

  tss_step #(.TICK_BITS(TICK_BITS)) u_step (
    .func              (in_func),
    .now               (in_now),
    .sys               (in_sys),
    .ok                (in_ok),
    .cfg               (cfg),
    .ctrl              (ctrl),
    .init_stamp        (init_stamp),
    .action_stamp      (action_stamp),
    .ctrl_next         (ctrl_next),
    .init_stamp_next   (init_stamp_next),
    .action_stamp_next (action_stamp_next),
    .res               (res_next)
  );

  // controller state commits as the call leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl         <= '0;
      init_stamp   <= '0;
      action_stamp <= '0;
    end else if (advance) begin
      ctrl         <= ctrl_next;
      init_stamp   <= init_stamp_next;
      action_stamp <= action_stamp_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res.idle, res.ready_res, res.state_value,
                    res.state_write, res.hard_stop, res.chassis_cmd,
                    res.cushion_cmd, res.serve_cmd};

endmodule

[hw/rtl/tss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the result stream of the sequencer.
// ----------------------------------------------------------------------------
module tss_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // state value is zero unless written
  a_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[7] |-> m_tdata[10:8] == 3'd0)
    else $error("state value without write");

  // a plain stop clears everything and sends no command
  a_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] && !m_tdata[7] |->
      m_tdata[12] && m_tdata[5:0] == 6'd0)
    else $error("stop with commands or busy");

  // a stop with a state write is a comms error and leaves the block idle
  a_comms: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] && m_tdata[7] |->
      m_tdata[10:8] == 3'd5 && m_tdata[12])
    else $error("bad comms error report");

endmodule

bind timed_serve_sequencer tss_checker u_tss_checker (.*);
